// ----- rtl/obox_pkg.sv -----
`timescale 1ns / 1ps

package obox_pkg;

	// field formats
	localparam int COORD_WIDTH   = 16;
	localparam int DIR_FRAC_BITS = 14;
	localparam int DIR_WIDTH     = DIR_FRAC_BITS + 2;
	localparam int SIZE_WIDTH    = 12;

	// internal widths, all exact
	localparam int DIFF_W = COORD_WIDTH + 1;                // center difference
	localparam int DD_W   = 2 * DIR_WIDTH + 1;              // heading dot heading
	localparam int DX_W   = DIFF_W + DIR_WIDTH + 1;         // offset dot heading
	localparam int PZ_W   = DD_W + SIZE_WIDTH;              // projection times size
	localparam int RHS_W  = PZ_W + 2;                       // sum of three terms
	localparam int LHS_W  = DX_W + DIR_FRAC_BITS + 1;       // scaled center distance
	localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;

	// stream words
	localparam int BOX_BITS    = 2 * COORD_WIDTH + 2 * DIR_WIDTH + 2 * SIZE_WIDTH;
	localparam int IN_BITS     = 2 * BOX_BITS;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = 8;

	// load enables of the back stages, shared by all axis slices
	typedef struct packed {
		logic s4;
		logic s5;
		logic s6;
	} obox_adv_t;

	function automatic logic [DD_W-1:0] mag_dd(input logic signed [DD_W-1:0] v);
		mag_dd = v[DD_W-1] ? unsigned'(-v) : unsigned'(v);
	endfunction

	function automatic logic [DX_W-1:0] mag_dx(input logic signed [DX_W-1:0] v);
		mag_dx = v[DX_W-1] ? unsigned'(-v) : unsigned'(v);
	endfunction

endpackage

// ----- rtl/obox_axis.sv -----
`timescale 1ns / 1ps

// One candidate separating axis: scale three projections by the box sizes,
// sum them into the projected radius and compare with the scaled distance.
module obox_axis (
	input  logic                                    clk,
	input  obox_pkg::obox_adv_t                     adv,
	input  logic [obox_pkg::DD_W-1:0]               m0,
	input  logic [obox_pkg::DD_W-1:0]               m1,
	input  logic [obox_pkg::DD_W-1:0]               m2,
	input  logic [obox_pkg::SIZE_WIDTH-1:0]         z0,
	input  logic [obox_pkg::SIZE_WIDTH-1:0]         z1,
	input  logic [obox_pkg::SIZE_WIDTH-1:0]         z2,
	input  logic [obox_pkg::DX_W-1:0]               gap,
	output logic                                    sep
);
	import obox_pkg::*;

	logic [PZ_W-1:0]  p0_s4, p1_s4, p2_s4;
	logic [DX_W-1:0]  gap_s4;
	logic [RHS_W-1:0] rhs_s5;
	logic [LHS_W-1:0] lhs_s5;
	logic             sep_s6;

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			p0_s4  <= PZ_W'(m0) * PZ_W'(z0);
			p1_s4  <= PZ_W'(m1) * PZ_W'(z1);
			p2_s4  <= PZ_W'(m2) * PZ_W'(z2);
			gap_s4 <= gap;
		end
		if (adv.s5) begin
			rhs_s5 <= RHS_W'(p0_s4) + RHS_W'(p1_s4) + RHS_W'(p2_s4);
			lhs_s5 <= {gap_s4, {(DIR_FRAC_BITS + 1){1'b0}}};
		end
		// strict: touching intervals do not separate
		if (adv.s6) begin
			sep_s6 <= CMP_W'(lhs_s5) > CMP_W'(rhs_s5);
		end
	end

	assign sep = sep_s6;

endmodule

// ----- rtl/oriented_box_overlap_test_unit.sv -----
`timescale 1ns / 1ps

// Channel  | Dir | Handshake               | Word
// ---------+-----+-------------------------+-------------------------------------
// s_axis   | in  | s_axis_tvalid/_tready   | box pair A, B (layout at the port)
// m_axis   | out | m_axis_tvalid/_tready   | overlap flag in bit 0
//
// Six register stages: center difference, heading products, dot sums and
// magnitudes, size products, radius sums, compare. One word per cycle while
// m_axis does not stall; the heading and size multipliers set the stage depth.
// Reset clears the stage valid bits only; payload registers are not reset.
// A stall on m_axis holds the last stage; each stage loads while it is empty or
// the one after it is empty or moving, so bubbles close up and nothing is lost.
module oriented_box_overlap_test_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// a_center_x, a_center_y, a_dir_x, a_dir_y, a_width, a_height,
	// b_center_x, b_center_y, b_dir_x, b_dir_y, b_width, b_height
	input  logic [obox_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// overlap, then zero fill
	output logic [obox_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
	import obox_pkg::*;

	// bit offsets inside one box record
	localparam int OFS_CX = 0;
	localparam int OFS_CY = OFS_CX + COORD_WIDTH;
	localparam int OFS_DX = OFS_CY + COORD_WIDTH;
	localparam int OFS_DY = OFS_DX + DIR_WIDTH;
	localparam int OFS_W  = OFS_DY + DIR_WIDTH;
	localparam int OFS_H  = OFS_W + SIZE_WIDTH;
	localparam int OFS_B  = BOX_BITS;

	// unpack the input word
	logic signed [COORD_WIDTH-1:0] acx, acy, bcx, bcy;
	logic signed [DIR_WIDTH-1:0]   adx, ady, bdx, bdy;
	logic [SIZE_WIDTH-1:0]         aw, ah, bw, bh;

	assign acx = s_axis_tdata[OFS_CX +: COORD_WIDTH];
	assign acy = s_axis_tdata[OFS_CY +: COORD_WIDTH];
	assign adx = s_axis_tdata[OFS_DX +: DIR_WIDTH];
	assign ady = s_axis_tdata[OFS_DY +: DIR_WIDTH];
	assign aw  = s_axis_tdata[OFS_W  +: SIZE_WIDTH];
	assign ah  = s_axis_tdata[OFS_H  +: SIZE_WIDTH];
	assign bcx = s_axis_tdata[OFS_B + OFS_CX +: COORD_WIDTH];
	assign bcy = s_axis_tdata[OFS_B + OFS_CY +: COORD_WIDTH];
	assign bdx = s_axis_tdata[OFS_B + OFS_DX +: DIR_WIDTH];
	assign bdy = s_axis_tdata[OFS_B + OFS_DY +: DIR_WIDTH];
	assign bw  = s_axis_tdata[OFS_B + OFS_W  +: SIZE_WIDTH];
	assign bh  = s_axis_tdata[OFS_B + OFS_H  +: SIZE_WIDTH];

	// stage valid bits and ready chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
	obox_adv_t adv;

	assign rdy6 = !v_s6 || m_axis_tready;
	assign rdy5 = !v_s5 || rdy6;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign s_axis_tready = rdy1;
	assign adv = '{s4: rdy4, s5: rdy5, s6: rdy6};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_axis_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	// stage 1: center offset B - A, hold headings and sizes
	logic signed [DIFF_W-1:0]    ox_s1, oy_s1;
	logic signed [DIR_WIDTH-1:0] adx_s1, ady_s1, bdx_s1, bdy_s1;
	logic [SIZE_WIDTH-1:0]       aw_s1, ah_s1, bw_s1, bh_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			ox_s1  <= DIFF_W'(bcx) - DIFF_W'(acx);
			oy_s1  <= DIFF_W'(bcy) - DIFF_W'(acy);
			adx_s1 <= adx;
			ady_s1 <= ady;
			bdx_s1 <= bdx;
			bdy_s1 <= bdy;
			aw_s1  <= aw;
			ah_s1  <= ah;
			bw_s1  <= bw;
			bh_s1  <= bh;
		end
	end

	// stage 2: all signed products
	// heading squares and cross terms; with n = (d.y, -d.x):
	//   dA.nA = dB.nB = 0, nA.nA = dA.dA, nA.nB = dA.dB, nA.dB = -(dA.nB)
	logic signed [DD_W-1:0] axax_s2, ayay_s2, bxbx_s2, byby_s2;
	logic signed [DD_W-1:0] axbx_s2, ayby_s2, axby_s2, aybx_s2;
	logic signed [DX_W-1:0] oxax_s2, oyay_s2, oxay_s2, oyax_s2;
	logic signed [DX_W-1:0] oxbx_s2, oyby_s2, oxby_s2, oybx_s2;
	logic [SIZE_WIDTH-1:0]  aw_s2, ah_s2, bw_s2, bh_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			axax_s2 <= DD_W'(adx_s1) * DD_W'(adx_s1);
			ayay_s2 <= DD_W'(ady_s1) * DD_W'(ady_s1);
			bxbx_s2 <= DD_W'(bdx_s1) * DD_W'(bdx_s1);
			byby_s2 <= DD_W'(bdy_s1) * DD_W'(bdy_s1);
			axbx_s2 <= DD_W'(adx_s1) * DD_W'(bdx_s1);
			ayby_s2 <= DD_W'(ady_s1) * DD_W'(bdy_s1);
			axby_s2 <= DD_W'(adx_s1) * DD_W'(bdy_s1);
			aybx_s2 <= DD_W'(ady_s1) * DD_W'(bdx_s1);
			oxax_s2 <= DX_W'(ox_s1) * DX_W'(adx_s1);
			oyay_s2 <= DX_W'(oy_s1) * DX_W'(ady_s1);
			oxay_s2 <= DX_W'(ox_s1) * DX_W'(ady_s1);
			oyax_s2 <= DX_W'(oy_s1) * DX_W'(adx_s1);
			oxbx_s2 <= DX_W'(ox_s1) * DX_W'(bdx_s1);
			oyby_s2 <= DX_W'(oy_s1) * DX_W'(bdy_s1);
			oxby_s2 <= DX_W'(ox_s1) * DX_W'(bdy_s1);
			oybx_s2 <= DX_W'(oy_s1) * DX_W'(bdx_s1);
			aw_s2   <= aw_s1;
			ah_s2   <= ah_s1;
			bw_s2   <= bw_s1;
			bh_s2   <= bh_s1;
		end
	end

	// stage 3: dot products reduced to magnitudes
	logic [DD_W-1:0]       sa_s3, sb_s3, pm_s3, qm_s3;
	logic [DX_W-1:0]       e0_s3, e1_s3, e2_s3, e3_s3;
	logic [SIZE_WIDTH-1:0] aw_s3, ah_s3, bw_s3, bh_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			sa_s3 <= mag_dd(axax_s2 + ayay_s2);
			sb_s3 <= mag_dd(bxbx_s2 + byby_s2);
			pm_s3 <= mag_dd(axbx_s2 + ayby_s2);
			qm_s3 <= mag_dd(axby_s2 - aybx_s2);
			e0_s3 <= mag_dx(oxax_s2 + oyay_s2);
			e1_s3 <= mag_dx(oxay_s2 - oyax_s2);
			e2_s3 <= mag_dx(oxbx_s2 + oyby_s2);
			e3_s3 <= mag_dx(oxby_s2 - oybx_s2);
			aw_s3 <= aw_s2;
			ah_s3 <= ah_s2;
			bw_s3 <= bw_s2;
			bh_s3 <= bh_s2;
		end
	end

	// stages 4 to 6: one slice per axis; the zero projection of a box onto
	// its own other axis drops out of that sum
	logic sep0, sep1, sep2, sep3;

	obox_axis u_axis_da (
		.clk(clk), .adv(adv),
		.m0(sa_s3), .m1(pm_s3), .m2(qm_s3),
		.z0(aw_s3), .z1(bw_s3), .z2(bh_s3),
		.gap(e0_s3), .sep(sep0)
	);

	obox_axis u_axis_na (
		.clk(clk), .adv(adv),
		.m0(sa_s3), .m1(qm_s3), .m2(pm_s3),
		.z0(ah_s3), .z1(bw_s3), .z2(bh_s3),
		.gap(e1_s3), .sep(sep1)
	);

	obox_axis u_axis_db (
		.clk(clk), .adv(adv),
		.m0(pm_s3), .m1(qm_s3), .m2(sb_s3),
		.z0(aw_s3), .z1(ah_s3), .z2(bw_s3),
		.gap(e2_s3), .sep(sep2)
	);

	obox_axis u_axis_nb (
		.clk(clk), .adv(adv),
		.m0(qm_s3), .m1(pm_s3), .m2(sb_s3),
		.z0(aw_s3), .z1(ah_s3), .z2(bh_s3),
		.gap(e3_s3), .sep(sep3)
	);

	// overlap unless any axis separates
	assign m_axis_tvalid = v_s6;
	assign m_axis_tdata  = {{(OUT_TDATA_W - 1){1'b0}}, !(sep0 || sep1 || sep2 || sep3)};

	// a full result held under backpressure stays valid
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && !m_axis_tready |=> v_s6)
		else $error("result word dropped while stalled");

	// input only blocks when every stage is occupied
	a_no_early_block: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6))
		else $error("input stalled with a free stage");

	// a zero heading of A gives zero cross projections
	a_zero_heading: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && (sa_s3 == '0) |-> (pm_s3 == '0) && (qm_s3 == '0))
		else $error("cross projection nonzero for zero heading");

endmodule
